@@ rtl/core/ordered_rank_set_macros.svh @@
// assertion macros shared by the ordered rank set modules
`ifndef ORDERED_RANK_SET_MACROS_SVH
`define ORDERED_RANK_SET_MACROS_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define ORS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off while reset is high
`define ORS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/ors_pkg.sv @@
// types, codes and default sizes for the ordered rank set
`timescale 1ns / 1ps

package ors_pkg;

   localparam int CAPACITY_DEFAULT   = 256;
   localparam int VALUE_BITS_DEFAULT = 17;
   localparam int HEIGHT_BITS        = 17;
   localparam int POSITION_BITS      = 8;
   localparam int RANK_BITS          = 8;
   localparam int STATUS_BITS        = 2;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_REMOVE = 1'b1
   } command_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_INSERTED = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_RANGE    = 2'd2
   } status_type;

   typedef struct packed {
      logic load;
      logic shift_insert;
      logic shift_remove;
      logic respond;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_remove;
      logic full;
      logic out_of_range;
   } dp_status_type;

endpackage

@@ rtl/core/ordered_rank_set.sv @@
// top level of the ordered rank set: controller and cell row datapath
`timescale 1ns / 1ps
// keeps up to CAPACITY values in descending order, largest at position 0
// request channel: req_command, req_height_value, req_position; a beat is
//    taken at a rising edge with start high and busy low
// insert (command 0) places the value and answers with its rank, the count
//    of stored values strictly greater; status 1 if the store is full
// remove (command 1) deletes the entry at req_position, later entries move up;
//    no answer on success, status 2 if the position is not below the count
// result channel: rsp_valid strobes for one cycle with rsp_rank, rsp_status;
//    the receiver cannot stall, so the beat must be taken in that cycle
// latency: the result strobe is in the second cycle after the accepting edge
// throughput: one request every 2 cycles; busy is high for the one commit
//    cycle in which the cell row shifts and the count updates
// each cell compares its value against the request at accept time; the
//    registered flags then steer the one-cycle shift of the whole row
// reset: count goes to zero and no strobe is pending; stored values are not
//    cleared, no clearing pass is needed
module ordered_rank_set #(
   parameter int CAPACITY   = ors_pkg::CAPACITY_DEFAULT,
   parameter int VALUE_BITS = ors_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_command,
   input  logic [ors_pkg::HEIGHT_BITS-1:0]    req_height_value,
   input  logic [ors_pkg::POSITION_BITS-1:0]  req_position,
   output logic                               rsp_valid,
   output logic [ors_pkg::RANK_BITS-1:0]      rsp_rank,
   output logic [ors_pkg::STATUS_BITS-1:0]    rsp_status
);

   ors_pkg::ctrl_cmd_type  cmd;
   ors_pkg::dp_status_type status;

   ors_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   ors_dpath #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_command      (req_command),
      .req_height_value (req_height_value),
      .req_position     (req_position),
      .rsp_valid        (rsp_valid),
      .rsp_rank         (rsp_rank),
      .rsp_status       (rsp_status)
   );

endmodule

@@ rtl/core/ors_ctrl.sv @@
// controller state machine for the ordered rank set
`timescale 1ns / 1ps
`include "ordered_rank_set_macros.svh"

module ors_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ors_pkg::dp_status_type status,
   output ors_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_COMMIT = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      commit;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy   = (state_ff == ST_COMMIT);
   assign commit = (state_ff == ST_COMMIT);

   assign cmd.load         = start && (state_ff == ST_IDLE);
   assign cmd.shift_insert = commit && !status.is_remove && !status.full;
   assign cmd.shift_remove = commit && status.is_remove && !status.out_of_range;
   assign cmd.respond      = commit && !(status.is_remove && !status.out_of_range);

   `ORS_ASSERT_NEXT(a_load_then_commit, cmd.load, state_ff == ST_COMMIT, "load not followed by commit")
   `ORS_ASSERT_NEXT(a_commit_single, state_ff == ST_COMMIT, state_ff == ST_IDLE, "commit held too long")
   `ORS_ASSERT_NOW(a_no_load_busy, busy, !cmd.load, "load while busy")

endmodule

@@ rtl/core/ors_dpath.sv @@
// compare-and-shift cell row, entry count and result register
`timescale 1ns / 1ps
`include "ordered_rank_set_macros.svh"

module ors_dpath #(
   parameter int CAPACITY   = ors_pkg::CAPACITY_DEFAULT,
   parameter int VALUE_BITS = ors_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ors_pkg::ctrl_cmd_type              cmd,
   output ors_pkg::dp_status_type             status,
   input  logic                               req_command,
   input  logic [ors_pkg::HEIGHT_BITS-1:0]    req_height_value,
   input  logic [ors_pkg::POSITION_BITS-1:0]  req_position,
   output logic                               rsp_valid,
   output logic [ors_pkg::RANK_BITS-1:0]      rsp_rank,
   output logic [ors_pkg::STATUS_BITS-1:0]    rsp_status
);

   localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_BITS = $clog2(CAPACITY + 1);
   localparam int CMP_BITS = (CNT_BITS > ors_pkg::POSITION_BITS) ? CNT_BITS
                                                                  : ors_pkg::POSITION_BITS;

   logic [VALUE_BITS-1:0]             cell_ff [CAPACITY];
   logic [VALUE_BITS-1:0]             cell_in [CAPACITY];
   logic [VALUE_BITS-1:0]             left_val [CAPACITY];
   logic [VALUE_BITS-1:0]             right_val [CAPACITY];
   logic [CAPACITY-1:0]               gt_ff, gt_in;
   logic [CAPACITY-1:0]               prev_gt;
   logic [CAPACITY-1:0]               first_zero;
   logic [VALUE_BITS-1:0]             value_ff, value_in;
   logic [ors_pkg::POSITION_BITS-1:0] pos_ff;
   ors_pkg::dp_status_type            status_ff, status_in;
   logic [CNT_BITS-1:0]               count_ff, count_in;
   logic [IDX_BITS-1:0]               rank;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [ors_pkg::RANK_BITS-1:0]     rsp_rank_ff, rsp_rank_in;
   ors_pkg::status_type               rsp_status_ff, rsp_status_in;

   assign value_in               = VALUE_BITS'(req_height_value);
   assign status_in.is_remove    = (req_command == ors_pkg::CMD_REMOVE);
   assign status_in.full         = (count_ff == CNT_BITS'(CAPACITY));
   assign status_in.out_of_range = (CMP_BITS'(req_position) >= CMP_BITS'(count_ff));

   // neighbour taps of the cell row
   always_comb begin
      left_val[0]            = value_ff;
      right_val[CAPACITY-1]  = cell_ff[CAPACITY-1];
      for (int i = 1; i < CAPACITY; i++) begin
         left_val[i]      = cell_ff[i-1];
         right_val[i-1]   = cell_ff[i];
      end
   end

   assign prev_gt    = {gt_ff[CAPACITY-2:0], 1'b1};
   assign first_zero = ~gt_ff & prev_gt;

   // per-cell compare and next value
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         gt_in[i]   = (CNT_BITS'(i) < count_ff) && (cell_ff[i] > value_in);
         cell_in[i] = cell_ff[i];
         if (cmd.shift_insert && !gt_ff[i]) begin
            cell_in[i] = prev_gt[i] ? value_ff : left_val[i];
         end else if (cmd.shift_remove && (CMP_BITS'(i) >= CMP_BITS'(pos_ff))) begin
            cell_in[i] = right_val[i];
         end
      end
   end

   // thermometer to binary rank
   always_comb begin
      rank = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rank = rank | (first_zero[i] ? IDX_BITS'(i) : '0);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.shift_insert) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (cmd.shift_remove) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_comb begin
      rsp_valid_in  = cmd.respond;
      rsp_rank_in   = '0;
      rsp_status_in = ors_pkg::STATUS_INSERTED;
      if (status_ff.is_remove) begin
         rsp_status_in = ors_pkg::STATUS_RANGE;
      end else if (status_ff.full) begin
         rsp_status_in = ors_pkg::STATUS_FULL;
      end else begin
         rsp_rank_in = ors_pkg::RANK_BITS'(rank);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         cell_ff[i] <= cell_in[i];
      end
      if (cmd.load) begin
         value_ff  <= value_in;
         pos_ff    <= req_position;
         gt_ff     <= gt_in;
         status_ff <= status_in;
      end
      if (cmd.respond) begin
         rsp_rank_ff   <= rsp_rank_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign status     = status_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_rank   = rsp_rank_ff;
   assign rsp_status = rsp_status_ff;

   `ORS_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_BITS'(CAPACITY), "count beyond capacity")
   `ORS_ASSERT_NOW(a_rsp_from_commit, rsp_valid_ff, $past(cmd.respond), "result beat without commit")
   `ORS_ASSERT_NEXT(a_insert_grows, cmd.shift_insert, count_ff == CNT_BITS'($past(count_ff) + 1'b1), "insert did not grow count")

endmodule
